>>> rtl/webm_cluster_block_framer_macros.svh
// assertion macros shared by the framer rtl
`ifndef WEBM_CLUSTER_BLOCK_FRAMER_MACROS_SVH
`define WEBM_CLUSTER_BLOCK_FRAMER_MACROS_SVH

`ifndef SYNTH
// checked on every rising edge outside reset
`define WCBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// checked on every rising edge, reset included
`define WCBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define WCBF_ASSERT(label, prop, msg)
`define WCBF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/wcbf_pkg.sv
package wcbf_pkg;

  // input op codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result kinds
  localparam logic KIND_CLOSE = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLUSTER_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_TRACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPS        = 2'd2;

  // configuration reset values
  localparam logic [14:0] MAX_CLUSTER_MS_RESET = 15'd1000;
  localparam logic [6:0]  VIDEO_TRACK_RESET    = 7'd1;

  // framing constants
  localparam int unsigned   MIN_DUR_MS      = 20;
  localparam logic [10:0]   MS_PER_SEC      = 11'd1000;
  localparam int unsigned   PAD_SLACK       = 16;
  localparam int unsigned   BLOCK_HDR_BYTES = 4;
  localparam logic [62:0]   WANT_CAP        = 63'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_PAD,
    ST_PADLEN,
    ST_PADADD,
    ST_REPORT,
    ST_BLOCK
  } wcbf_state_e;

  // shortest ebml vint length whose all-ones code lies above n
  function automatic logic [3:0] vint_len(logic [31:0] n);
    logic [3:0] len;
    len = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if ({32'd0, n} >= ((64'd1 << (7 * i)) - 64'd1)) begin
        len = 4'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

>>> rtl/webm_cluster_block_framer.sv
// WebM cluster / SimpleBlock framer. Each input transfer is either a block
// descriptor (op 0) or a flush of the open cluster (op 1). Block times are
// clamped so they never run backwards; an open cluster is closed ahead of a
// block on a video-track keyframe or once its age reaches max_cluster_ms.
// A close first sizes a Void pad, when min_bytes_per_sec is nonzero, so
// that the body meets that rate (duration at least 20 ms, 16 bytes slack),
// then sends a close report (kind 0); a block then sends its SimpleBlock
// header fields (kind 1). last marks the final result of an input transfer;
// a flush with no open cluster gives no result. Timing: the block takes one
// item at a time and holds in_stall_o high while it works. A close with
// padding runs the bit-serial shift-add multiplier (TIME_BITS steps) and the
// bit-serial restoring divide by 1000 (32 + TIME_BITS steps), which share
// one product register, then the pad sizing states PAD, PADLEN and PADADD,
// and then the report. A result waiting in the output register does not
// stop the next item from being accepted.
// No clearing pass follows reset. Configuration must be written only while
// idle; the block itself does not enforce this.
`include "webm_cluster_block_framer_macros.svh"

module webm_cluster_block_framer #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned BODY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_op_i,
  input  logic [6:0]  in_track_i,
  input  logic [39:0] in_time_ms_i,
  input  logic        in_keyframe_i,
  input  logic [23:0] in_payload_bytes_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [39:0] out_cluster_time_o,
  output logic        out_cluster_key_o,
  output logic [31:0] out_pad_bytes_o,
  output logic [3:0]  out_pad_size_len_o,
  output logic [31:0] out_cluster_body_bytes_o,
  output logic [6:0]  out_block_track_o,
  output logic signed [15:0] out_rel_time_o,
  output logic        out_block_key_o,
  output logic [24:0] out_block_size_o,
  output logic [3:0]  out_block_size_len_o,
  output logic        out_last_o
);

  import wcbf_pkg::*;

  // product register holds multiplier, then product, then quotient
  localparam int unsigned PW   = 32 + TIME_BITS;
  localparam int unsigned CW   = $clog2(PW);
  // body sums need room for a 33-bit pad increment
  localparam int unsigned SUMW = ((BODY_BITS > 33) ? BODY_BITS : 33) + 1;

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  wcbf_state_e state_q, state_d;

  // configuration
  logic [14:0] max_ms_q;
  logic [6:0]  vtrack_q;
  logic [31:0] min_bps_q;

  // cluster and stream state
  logic                 cluster_open_q;
  logic [TIME_BITS-1:0] start_q;
  logic                 starts_key_q;
  logic [TIME_BITS-1:0] latest_q;
  logic [BODY_BITS-1:0] body_q;

  // latched item
  logic                 op_q;
  logic [6:0]           track_q;
  logic [TIME_BITS-1:0] t_q;
  logic                 key_q;
  logic [23:0]          payload_q;
  logic                 vkey_q;

  // padding datapath
  logic [PW-1:0] p_q;
  logic [9:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   pad_q;
  logic [3:0]    plen_q;
  logic          pad_hit_q;

  // output register
  logic        out_valid_q;
  logic        out_kind_q;
  logic [39:0] out_ctime_q;
  logic        out_ckey_q;
  logic [31:0] out_pad_q;
  logic [3:0]  out_plen_q;
  logic [31:0] out_body_q;
  logic [6:0]  out_track_q;
  logic [15:0] out_rel_q;
  logic        out_bkey_q;
  logic [24:0] out_bsize_q;
  logic [3:0]  out_blen_q;
  logic        out_last_q;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  logic in_xfer;
  logic out_free;
  logic close_start;
  logic load_report;
  logic load_block;

  assign in_xfer  = in_valid_i && !in_stall_o;
  // output register can take a result when empty or emptying this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------
  // combinational datapath
  // ---------------------------------------------------------------------
  logic [63:0]          time64;
  logic [TIME_BITS-1:0] in_t;
  logic [TIME_BITS-1:0] t_clamped;
  logic [TIME_BITS-1:0] age;
  logic                 vkey_c;
  logic                 close_now;
  logic                 pad_en;

  assign time64    = 64'(in_time_ms_i);
  // time is taken modulo 2^TIME_BITS
  assign in_t      = time64[TIME_BITS-1:0];
  assign t_clamped = (t_q < latest_q) ? latest_q : t_q;
  assign age       = t_q - start_q;
  assign vkey_c    = (track_q == vtrack_q) && key_q;
  assign close_now = cluster_open_q && (vkey_c || (age >= TIME_BITS'(max_ms_q)));
  assign pad_en    = (min_bps_q != 32'd0);

  // cluster duration for padding, floored at the minimum
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] dur_fl;

  assign dur    = latest_q - start_q;
  assign dur_fl = (dur < TIME_BITS'(MIN_DUR_MS)) ? TIME_BITS'(MIN_DUR_MS) : dur;

  // one shift-add step of rate * duration
  logic [32:0] mul_sum;

  assign mul_sum = {1'b0, p_q[PW-1:TIME_BITS]} + (p_q[0] ? {1'b0, min_bps_q} : 33'd0);

  // one restoring step of the divide by 1000
  logic [10:0] div_t;
  logic        div_ge;
  logic [10:0] div_sub;

  assign div_t   = {rem_q, p_q[PW-1]};
  assign div_ge  = (div_t >= MS_PER_SEC);
  assign div_sub = div_t - MS_PER_SEC;

  // wanted body bytes and pad size
  logic [62:0] want;
  logic [63:0] want64;
  logic [63:0] body_slack;
  logic [63:0] pad_diff;
  logic        pad_hit_c;
  logic [31:0] pad_sat;

  assign want       = (|p_q[PW-1:62]) ? WANT_CAP : p_q[62:0];
  assign want64     = {1'b0, want};
  assign body_slack = 64'(body_q) + 64'(PAD_SLACK);
  assign pad_hit_c  = (body_slack < want64);
  assign pad_diff   = want64 - body_slack;
  assign pad_sat    = (|pad_diff[63:32]) ? 32'hFFFF_FFFF : pad_diff[31:0];

  // body grows by the Void element: id byte, size vint, pad bytes
  logic [SUMW-1:0]      pad_body_sum;
  logic [BODY_BITS-1:0] pad_body_next;

  assign pad_body_sum  = SUMW'(body_q) + SUMW'(pad_q) + SUMW'(plen_q) + SUMW'(1);
  assign pad_body_next = (|pad_body_sum[SUMW-1:BODY_BITS]) ? {BODY_BITS{1'b1}}
                                                           : pad_body_sum[BODY_BITS-1:0];

  // SimpleBlock header fields and body growth
  logic [24:0]          bsize;
  logic [3:0]           blen;
  logic [BODY_BITS-1:0] blk_base;
  logic [SUMW-1:0]      blk_body_sum;
  logic [BODY_BITS-1:0] blk_body_next;
  logic [TIME_BITS-1:0] blk_start;
  logic [TIME_BITS-1:0] blk_rel;

  assign bsize         = 25'(payload_q) + 25'(BLOCK_HDR_BYTES);
  assign blen          = vint_len(32'(bsize));
  // a closed or never opened cluster starts at this block
  assign blk_base      = cluster_open_q ? body_q : '0;
  assign blk_start     = cluster_open_q ? start_q : t_q;
  assign blk_rel       = t_q - blk_start;
  assign blk_body_sum  = SUMW'(blk_base) + SUMW'(bsize) + SUMW'(blen) + SUMW'(1);
  assign blk_body_next = (|blk_body_sum[SUMW-1:BODY_BITS]) ? {BODY_BITS{1'b1}}
                                                           : blk_body_sum[BODY_BITS-1:0];

  // close report views of the stored state
  logic [63:0] start64;
  logic [63:0] body64;

  assign start64 = 64'(start_q);
  assign body64  = 64'(body_q);

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op_i == OP_FLUSH) begin
            if (cluster_open_q) begin
              state_d = pad_en ? ST_MUL : ST_REPORT;
            end
          end else begin
            state_d = ST_CLAMP;
          end
        end
      end
      ST_CLAMP:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (close_now) begin
          state_d = pad_en ? ST_MUL : ST_REPORT;
        end else begin
          state_d = ST_BLOCK;
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD:    state_d = ST_PADLEN;
      ST_PADLEN: state_d = ST_PADADD;
      ST_PADADD: state_d = ST_REPORT;
      ST_REPORT: begin
        if (out_free) begin
          state_d = (op_q == OP_FLUSH) ? ST_IDLE : ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    close_start = ((state_q == ST_IDLE) && in_xfer && (in_op_i == OP_FLUSH) &&
                   cluster_open_q) ||
                  ((state_q == ST_DECIDE) && close_now);
    load_report = (state_q == ST_REPORT) && out_free;
    load_block  = (state_q == ST_BLOCK) && out_free;
  end

  // ---------------------------------------------------------------------
  // control and cluster registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      max_ms_q       <= MAX_CLUSTER_MS_RESET;
      vtrack_q       <= VIDEO_TRACK_RESET;
      min_bps_q      <= '0;
      cluster_open_q <= 1'b0;
      start_q        <= '0;
      starts_key_q   <= 1'b0;
      latest_q       <= '0;
      body_q         <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_CLUSTER_MS: max_ms_q  <= cfg_wdata_i[14:0];
          CFG_VIDEO_TRACK:    vtrack_q  <= cfg_wdata_i[6:0];
          CFG_MIN_BPS:        min_bps_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // time never runs backwards
      if (state_q == ST_CLAMP) begin
        latest_q <= t_clamped;
      end

      // bit counter for multiply then divide
      if (close_start) begin
        cnt_q <= CW'(TIME_BITS - 1);
      end else if (state_q == ST_MUL) begin
        cnt_q <= (cnt_q == '0) ? CW'(PW - 1) : cnt_q - CW'(1);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - CW'(1);
      end

      if ((state_q == ST_PADADD) && pad_hit_q) begin
        body_q <= pad_body_next;
      end

      // close report empties the cluster
      if (load_report) begin
        cluster_open_q <= 1'b0;
        starts_key_q   <= 1'b0;
        start_q        <= '0;
        body_q         <= '0;
      end

      if (load_block) begin
        if (!cluster_open_q) begin
          cluster_open_q <= 1'b1;
          start_q        <= t_q;
          starts_key_q   <= vkey_q;
        end
        body_q <= blk_body_next;
      end

      if (load_report || load_block) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= in_op_i;
      track_q   <= in_track_i;
      t_q       <= in_t;
      key_q     <= in_keyframe_i;
      payload_q <= in_payload_bytes_i;
    end else if (state_q == ST_CLAMP) begin
      t_q <= t_clamped;
    end

    if (state_q == ST_DECIDE) begin
      vkey_q <= vkey_c;
    end

    if (close_start) begin
      p_q       <= {32'd0, dur_fl};
      rem_q     <= '0;
      pad_q     <= '0;
      plen_q    <= '0;
      pad_hit_q <= 1'b0;
    end else if (state_q == ST_MUL) begin
      p_q <= {mul_sum, p_q[TIME_BITS-1:1]};
    end else if (state_q == ST_DIV) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      p_q   <= {p_q[PW-2:0], div_ge};
      rem_q <= div_ge ? div_sub[9:0] : div_t[9:0];
    end else if (state_q == ST_PAD) begin
      pad_hit_q <= pad_hit_c;
      pad_q     <= pad_hit_c ? pad_sat : 32'd0;
    end else if (state_q == ST_PADLEN) begin
      plen_q <= pad_hit_q ? vint_len(pad_q) : 4'd0;
    end

    if (load_report) begin
      out_kind_q  <= KIND_CLOSE;
      out_ctime_q <= start64[39:0];
      out_ckey_q  <= starts_key_q;
      out_pad_q   <= pad_q;
      out_plen_q  <= plen_q;
      out_body_q  <= (|body64[63:32]) ? 32'hFFFF_FFFF : body64[31:0];
      out_track_q <= '0;
      out_rel_q   <= '0;
      out_bkey_q  <= 1'b0;
      out_bsize_q <= '0;
      out_blen_q  <= '0;
      out_last_q  <= (op_q == OP_FLUSH);
    end else if (load_block) begin
      out_kind_q  <= KIND_BLOCK;
      out_ctime_q <= '0;
      out_ckey_q  <= 1'b0;
      out_pad_q   <= '0;
      out_plen_q  <= '0;
      out_body_q  <= '0;
      out_track_q <= track_q;
      out_rel_q   <= blk_rel[15:0];
      out_bkey_q  <= key_q;
      out_bsize_q <= bsize;
      out_blen_q  <= blen;
      out_last_q  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------
  assign out_valid_o              = out_valid_q;
  assign out_kind_o               = out_kind_q;
  assign out_cluster_time_o       = out_ctime_q;
  assign out_cluster_key_o        = out_ckey_q;
  assign out_pad_bytes_o          = out_pad_q;
  assign out_pad_size_len_o       = out_plen_q;
  assign out_cluster_body_bytes_o = out_body_q;
  assign out_block_track_o        = out_track_q;
  assign out_rel_time_o           = out_rel_q;
  assign out_block_key_o          = out_bkey_q;
  assign out_block_size_o         = out_bsize_q;
  assign out_block_size_len_o     = out_blen_q;
  assign out_last_o               = out_last_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `WCBF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result during reset")
  `WCBF_ASSERT(a_mul_count, (state_q == ST_MUL) |-> (cnt_q < CW'(TIME_BITS)), "mul count")
  `WCBF_ASSERT(a_report_clears, load_report |=> (!cluster_open_q && (body_q == '0)), "close")
  `WCBF_ASSERT(a_block_opens, load_block |=> cluster_open_q, "block left cluster closed")
  `WCBF_ASSERT(a_pad_pair, (out_valid_o && (out_kind_o == KIND_CLOSE)) |-> ((out_pad_bytes_o == 32'd0) == (out_pad_size_len_o == 4'd0)), "pad size")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wcbf_pkg::*;

  // cycles to let a flush with nothing open (or a padded close) drain
  localparam int unsigned SETTLE_CYCLES = 200;
  // cycles with no transfer or register write before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam longint unsigned BODY_LIMIT = 64'hFFFF_FFFF;
  localparam longint unsigned WANT_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic [39:0] TIME_ALL_ONES = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [6:0]  track;
    logic [39:0] time_ms;
    logic        keyframe;
    logic [23:0] payload;
  } descriptor_t;

  typedef struct packed {
    logic        kind;
    logic [39:0] cluster_time;
    logic        cluster_key;
    logic [31:0] pad_bytes;
    logic [3:0]  pad_size_len;
    logic [31:0] cluster_body_bytes;
    logic [6:0]  block_track;
    logic [15:0] rel_time;
    logic        block_key;
    logic [24:0] block_size;
    logic [3:0]  block_size_len;
    logic        last;
  } framer_report_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_op_i = OP_ADD;
  logic [6:0]  in_track_i = '0;
  logic [39:0] in_time_ms_i = '0;
  logic        in_keyframe_i = 1'b0;
  logic [23:0] in_payload_bytes_i = '0;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_kind_o;
  logic [39:0] out_cluster_time_o;
  logic        out_cluster_key_o;
  logic [31:0] out_pad_bytes_o;
  logic [3:0]  out_pad_size_len_o;
  logic [31:0] out_cluster_body_bytes_o;
  logic [6:0]  out_block_track_o;
  logic signed [15:0] out_rel_time_o;
  logic        out_block_key_o;
  logic [24:0] out_block_size_o;
  logic [3:0]  out_block_size_len_o;
  logic        out_last_o;

  webm_cluster_block_framer i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .in_op_i                 (in_op_i),
    .in_track_i              (in_track_i),
    .in_time_ms_i            (in_time_ms_i),
    .in_keyframe_i           (in_keyframe_i),
    .in_payload_bytes_i      (in_payload_bytes_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_kind_o              (out_kind_o),
    .out_cluster_time_o      (out_cluster_time_o),
    .out_cluster_key_o       (out_cluster_key_o),
    .out_pad_bytes_o         (out_pad_bytes_o),
    .out_pad_size_len_o      (out_pad_size_len_o),
    .out_cluster_body_bytes_o(out_cluster_body_bytes_o),
    .out_block_track_o       (out_block_track_o),
    .out_rel_time_o          (out_rel_time_o),
    .out_block_key_o         (out_block_key_o),
    .out_block_size_o        (out_block_size_o),
    .out_block_size_len_o    (out_block_size_len_o),
    .out_last_o              (out_last_o)
  );

  // stimulus and expectation stores
  descriptor_t    descriptor_q[$];
  framer_report_t framer_reports_q[$];
  descriptor_t    cur_desc;

  // percentage of cycles in which either side holds back
  int unsigned idle_pct = 14;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  longint unsigned time_cursor = 0;

  // shadow of the configuration registers
  logic [14:0] cfg_max_ms = MAX_CLUSTER_MS_RESET;
  logic [6:0]  cfg_video = VIDEO_TRACK_RESET;
  logic [31:0] cfg_min_bps = '0;

  // shadow of the cluster state
  logic            clu_open = 1'b0;
  logic [39:0]     clu_start = '0;
  logic            clu_key = 1'b0;
  logic [39:0]     latest_ms = '0;
  longint unsigned body_bytes = 0;

  // --------------------------------------------------------------------------
  // store access
  // --------------------------------------------------------------------------

  function automatic void add_descriptor(descriptor_t d);
    descriptor_q.insert(descriptor_q.size(), d);
  endfunction

  function automatic descriptor_t take_descriptor();
    descriptor_t d;
    d = descriptor_q[0];
    descriptor_q.delete(0);
    return d;
  endfunction

  function automatic void add_expected(framer_report_t r);
    framer_reports_q.insert(framer_reports_q.size(), r);
  endfunction

  function automatic framer_report_t take_expected();
    framer_report_t r;
    r = framer_reports_q[0];
    framer_reports_q.delete(0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // framing predictor
  // --------------------------------------------------------------------------

  // shortest ebml size length; the all-ones code of each length is reserved
  function automatic logic [3:0] ebml_size_len(longint unsigned n);
    logic [3:0] len;
    len = 4'd1;
    while (len < 4'd8 && n >= ((64'd1 << (7 * len)) - 64'd1)) len++;
    return len;
  endfunction

  // body counter saturates instead of wrapping
  function automatic void body_grow(longint unsigned n);
    longint unsigned sum;
    sum = body_bytes + n;
    body_bytes = (sum > BODY_LIMIT) ? BODY_LIMIT : sum;
  endfunction

  // sizes the void pad, builds the close report and empties the cluster
  function automatic framer_report_t close_cluster();
    framer_report_t  r;
    longint unsigned dur, q, rem, want, pad, rate;
    logic [3:0]      plen;
    r = '0;
    pad = 0;
    plen = '0;
    if (cfg_min_bps != '0) begin
      rate = 64'(cfg_min_bps);
      dur = 64'(latest_ms - clu_start);
      if (dur < 20) dur = 20;
      q = dur / 1000;
      rem = dur % 1000;
      // split so the product cannot overflow before the cap
      if (q != 0 && q > WANT_LIMIT / rate) want = WANT_LIMIT;
      else want = rate * q + (rate * rem) / 1000;
      if (want > WANT_LIMIT) want = WANT_LIMIT;
      if (body_bytes + 16 < want) begin
        pad = want - body_bytes - 16;
        if (pad > 64'hFFFF_FFFF) pad = 64'hFFFF_FFFF;
        plen = ebml_size_len(pad);
        body_grow(1 + plen + pad);
      end
    end
    r.kind = KIND_CLOSE;
    r.cluster_time = clu_start;
    r.cluster_key = clu_key;
    r.pad_bytes = pad[31:0];
    r.pad_size_len = plen;
    r.cluster_body_bytes = (body_bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : body_bytes[31:0];
    clu_open = 1'b0;
    clu_key = 1'b0;
    clu_start = '0;
    body_bytes = 0;
    return r;
  endfunction

  // computes the results of one accepted descriptor
  task automatic frame_descriptor(descriptor_t d);
    framer_report_t r;
    logic [39:0]    t, age;
    logic [24:0]    bsize;
    logic [3:0]     blen;
    logic           vkey;
    if (d.op == OP_FLUSH) begin
      // a flush with nothing open is silently dropped
      if (clu_open) begin
        r = close_cluster();
        r.last = 1'b1;
        add_expected(r);
      end
      return;
    end
    // time never runs backwards
    t = (d.time_ms < latest_ms) ? latest_ms : d.time_ms;
    latest_ms = t;
    vkey = (d.track == cfg_video) && d.keyframe;
    if (clu_open && (vkey || (t - clu_start) >= cfg_max_ms)) begin
      r = close_cluster();
      add_expected(r);
    end
    if (!clu_open) begin
      clu_open = 1'b1;
      clu_start = t;
      clu_key = vkey;
      body_bytes = 0;
    end
    bsize = 25'd4 + 25'(d.payload);
    blen = ebml_size_len(64'(bsize));
    body_grow(1 + blen + bsize);
    age = t - clu_start;
    r = '0;
    r.kind = KIND_BLOCK;
    r.block_track = d.track;
    r.rel_time = age[15:0];
    r.block_key = d.keyframe;
    r.block_size = bsize;
    r.block_size_len = blen;
    r.last = 1'b1;
    add_expected(r);
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic log_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      log_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                             results_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // clock, driver, monitor, watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver: a payload stays put while stalled, the next one follows
  // the transfer directly unless this cycle is picked as a gap
  always @(posedge clk_i) begin : descriptor_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      // transfer at this edge: predict from the payload that was on the bus
      if (in_valid_i) frame_descriptor(cur_desc);
      if (descriptor_q.size() != 0 && !(idle_pct != 0 && $urandom_range(99) < idle_pct)) begin
        cur_desc = take_descriptor();
        in_op_i <= cur_desc.op;
        in_track_i <= cur_desc.track;
        in_time_ms_i <= cur_desc.time_ms;
        in_keyframe_i <= cur_desc.keyframe;
        in_payload_bytes_i <= cur_desc.payload;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor: every transfer is matched against the oldest expectation
  always @(posedge clk_i) begin : report_monitor
    framer_report_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (framer_reports_q.size() == 0) begin
          log_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                 results_seen, out_kind_o));
        end else begin
          want = take_expected();
          check_field("kind", out_kind_o, want.kind);
          check_field("cluster_time", out_cluster_time_o, want.cluster_time);
          check_field("cluster_key", out_cluster_key_o, want.cluster_key);
          check_field("pad_bytes", out_pad_bytes_o, want.pad_bytes);
          check_field("pad_size_len", out_pad_size_len_o, want.pad_size_len);
          check_field("cluster_body_bytes", out_cluster_body_bytes_o,
                      want.cluster_body_bytes);
          check_field("block_track", out_block_track_o, want.block_track);
          check_field("rel_time", $unsigned(out_rel_time_o), want.rel_time);
          check_field("block_key", out_block_key_o, want.block_key);
          check_field("block_size", out_block_size_o, want.block_size);
          check_field("block_size_len", out_block_size_len_o, want.block_size_len);
          check_field("last", out_last_o, want.last);
        end
        results_seen++;
      end
      out_stall_i <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  // hang detection: any transfer or register write restarts the count
  always @(posedge clk_i) begin : hang_watchdog
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("webm_cluster_block_framer verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  task automatic queue_block(logic [6:0] trk, logic [39:0] ms, logic key, logic [23:0] bytes);
    descriptor_t d;
    d.op = OP_ADD;
    d.track = trk;
    d.time_ms = ms;
    d.keyframe = key;
    d.payload = bytes;
    add_descriptor(d);
  endtask

  task automatic queue_flush();
    descriptor_t d;
    d = '0;
    d.op = OP_FLUSH;
    add_descriptor(d);
  endtask

  // block is idle once nothing is queued, pending or expected and the
  // longest close has had time to finish
  task automatic wait_quiet();
    while (descriptor_q.size() != 0 || in_valid_i || framer_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register per edge; the shadow follows the write
  task automatic write_config(logic [14:0] max_ms, logic [6:0] video, logic [31:0] min_bps);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MAX_CLUSTER_MS;
    cfg_wdata_i <= 32'(max_ms);
    cfg_max_ms = max_ms;
    @(posedge clk_i);
    cfg_index_i <= CFG_VIDEO_TRACK;
    cfg_wdata_i <= 32'(video);
    cfg_video = video;
    @(posedge clk_i);
    cfg_index_i <= CFG_MIN_BPS;
    cfg_wdata_i <= min_bps;
    cfg_min_bps = min_bps;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly forward-moving block streams sized to the cluster age limit,
  // with some late blocks, big time jumps and flushes mixed in
  task automatic queue_random(int unsigned count, int unsigned span);
    descriptor_t     d;
    longint unsigned t;
    int unsigned     pick;
    repeat (count) begin
      d.op = ($urandom_range(99) < 7) ? OP_FLUSH : OP_ADD;
      d.track = ($urandom_range(1) != 0) ? cfg_video : 7'($urandom_range(127));
      d.keyframe = ($urandom_range(99) < 30);
      case ($urandom_range(9))
        0: d.payload = 24'($urandom);
        1: d.payload = 24'hFF_FFFF - 24'($urandom_range(3));
        // sizes just past the first vint length step and on both sides of the next two
        2: begin
          case ($urandom_range(5))
            0: d.payload = 24'd123;
            1: d.payload = 24'd124;
            2: d.payload = 24'd16378;
            3: d.payload = 24'd16379;
            4: d.payload = 24'd2097146;
            default: d.payload = 24'd2097147;
          endcase
        end
        default: d.payload = 24'($urandom_range(300));
      endcase
      if (d.op == OP_FLUSH) begin
        // a flush ignores its time, so use it to toggle the upper bits
        d.time_ms = {8'($urandom), 32'($urandom)};
      end else begin
        pick = $urandom_range(19);
        if (pick == 0) t = (time_cursor > 200) ? time_cursor - $urandom_range(200) : 0;
        else if (pick == 1) t = time_cursor + 2 * span + $urandom_range(5000);
        else t = time_cursor + $urandom_range(span);
        if (t > time_cursor) time_cursor = t;
        d.time_ms = t[39:0];
      end
      add_descriptor(d);
    end
  endtask

  task automatic run_phase(logic [14:0] max_ms, logic [6:0] video, logic [31:0] min_bps,
                           int unsigned count, int unsigned span, int unsigned gaps);
    wait_quiet();
    idle_pct = gaps;
    write_config(max_ms, video, min_bps);
    queue_random(count, span);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: age limit 1000 ms, video track 1, no padding
    queue_flush();                                 // nothing open yet
    queue_block(7'd1, 40'd0, 1'b1, 24'd0);          // smallest block, keyed cluster
    queue_block(7'd2, 40'd5, 1'b0, 24'd123);        // size 127 needs two bytes
    queue_block(7'd127, 40'd2, 1'b1, 24'd124);      // late time, non-video key
    queue_block(7'd0, 40'd999, 1'b0, 24'd16379);    // track zero, just under age
    queue_block(7'd1, 40'd1000, 1'b0, 24'd2097147); // age limit reached
    queue_block(7'd1, 40'd1000, 1'b1, 24'hFF_FFFF); // video key closes, max payload
    queue_flush();
    queue_flush();                                 // second flush finds nothing

    // padding on: minimum duration, then a long cluster
    wait_quiet();
    write_config(15'd1000, 7'd1, 32'd100000);
    queue_block(7'd2, 40'd1010, 1'b0, 24'd10);
    queue_flush();
    queue_block(7'd3, 40'd1020, 1'b0, 24'd0);
    queue_block(7'd3, 40'd3500, 1'b0, 24'd5);
    time_cursor = 4000;

    run_phase(15'd1000, 7'd1, 32'd0, 240, 400, 14);
    run_phase(15'd1, 7'd127, 32'd1, 240, 3, 14);
    run_phase(15'd32767, 7'd5, 32'hFFFF_FFFF, 240, 20000, 14);
    // zero age limit, and a long stretch with no gaps on either side
    run_phase(15'd0, 7'd1, 32'd50000, 240, 30, 0);
    run_phase(15'($urandom_range(5000, 2)), 7'($urandom_range(126, 1)), 32'($urandom),
              240, 1500, 14);
    wait_quiet();
    time_cursor += 64'h1_0000_0000 + $urandom_range(100000);
    run_phase(15'd500, 7'd2, 32'd12345678, 240, 300, 14);

    // top rate and a jump to the last millisecond: wanted bytes, pad and
    // body count all saturate
    wait_quiet();
    write_config(15'd32767, 7'd1, 32'hFFFF_FFFF);
    queue_flush();
    queue_block(7'd2, time_cursor[39:0], 1'b0, 24'd0);
    queue_block(7'd2, TIME_ALL_ONES, 1'b1, 24'hFF_FFFF);
    queue_block(7'd127, 40'd0, 1'b1, 24'd0);
    queue_flush();

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("webm_cluster_block_framer verification clean");
    end else begin
      $display("webm_cluster_block_framer verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/wcbf_pkg.sv
rtl/webm_cluster_block_framer.sv
tb/tb_top.sv
